/* sv/ple_pkg.sv */
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared sizes, operation codes and status codes of the list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  // Number of list entries the store can hold (2 to 63).
  localparam int unsigned DEPTH = 32;

  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned OP_W      = 3;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned POS_EXT_W = POS_W + 1;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned COUNT_W   = 6;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_DUMP      = 3'd6
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

endpackage

`default_nettype wire

/* sv/ple_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // A read of the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/positional_list_engine.sv */
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed words kept front first in a RAM, with insert and
// delete at front, back or a 1-based position, and a front-to-back dump.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   -------   ----------------   ------------------------------------
//   command   start_i / busy_o   op_i, value_i, pos_i
//   result    done_o (strobe)    status_o, count_o, value_out_o, last_o
//
// A result is on the ports for the cycle that follows the edge that finishes
// its work. A command that moves no words (errors, appends, delete of the
// last word) keeps busy_o low, so a command can be taken every cycle.
// Insert at index i (0-based) below the end of a list keeps busy_o high while
// it moves the words from the last one down to index i one slot back, then
// writes the new word; delete at index i moves the words above it one slot
// forward, and dump reads every word in turn: each moved or dumped word goes
// through the single RAM read port. Reset clears the count; the RAM needs no
// clearing since only slots below the count are read. Results cannot be stalled.

`default_nettype none

module positional_list_engine
  import ple_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic signed [VAL_W-1:0]  value_i,
  input  logic [POS_W-1:0]         pos_i,
  output logic                     done_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [COUNT_W-1:0]       count_o,
  output logic signed [VAL_W-1:0]  value_out_o,
  output logic                     last_o
);

  typedef enum logic [2:0] {
    S_WAIT  = 3'd0,
    S_SHUP  = 3'd1,
    S_PUT   = 3'd2,
    S_SHDN  = 3'd3,
    S_DUMP  = 3'd4
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ADDR_W-1:0]   cur_q, cur_d;
  logic [ADDR_W-1:0]   tgt_q, tgt_d;
  logic [VAL_W-1:0]    val_q, val_d;
  logic                done_q, done_d;
  status_e             status_q, status_d;
  logic [VAL_W-1:0]    vout_q, vout_d;
  logic                last_q, last_d;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [VAL_W-1:0]    mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [VAL_W-1:0]    mem_rdata;

  op_e                 op;
  logic                full;
  logic                empty;
  logic [POS_EXT_W-1:0] pos_w;
  logic [POS_EXT_W-1:0] cnt_w;
  logic [ADDR_W-1:0]   pos_idx;
  logic [ADDR_W-1:0]   last_idx;
  logic [ADDR_W-1:0]   ins_idx;
  logic [ADDR_W-1:0]   del_idx;
  logic                ins_bad;
  logic                del_bad;

  assign op       = op_e'(op_i);
  assign full     = (cnt_q == CNT_W'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign pos_w    = POS_EXT_W'(pos_i);
  assign cnt_w    = POS_EXT_W'(cnt_q);
  assign pos_idx  = ADDR_W'(pos_i - POS_W'(1));
  assign last_idx = ADDR_W'(cnt_q - CNT_W'(1));
  assign ins_bad  = (op == OP_INS_POS) &&
                    ((pos_w == '0) || (pos_w > cnt_w + POS_EXT_W'(1)));
  assign del_bad  = (op == OP_DEL_POS) && ((pos_w == '0) || (pos_w > cnt_w));

  always_comb begin
    case (op)
      OP_INS_FRONT: ins_idx = '0;
      OP_INS_BACK:  ins_idx = ADDR_W'(cnt_q);
      default:      ins_idx = pos_idx;
    endcase
    case (op)
      OP_DEL_FRONT: del_idx = '0;
      OP_DEL_BACK:  del_idx = last_idx;
      default:      del_idx = pos_idx;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    tgt_d     = tgt_q;
    val_d     = val_q;
    done_d    = 1'b0;
    status_d  = status_q;
    vout_d    = vout_q;
    last_d    = last_q;
    mem_we    = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = mem_rdata;
    mem_raddr = cur_q;

    unique case (state_q)
      S_WAIT: begin
        if (start_i) begin
          // Every path here that finishes at once reports a single word.
          done_d   = 1'b1;
          status_d = ST_OK;
          vout_d   = '0;
          last_d   = 1'b1;
          unique case (op) inside
            OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
              if (full) begin
                status_d = ST_FULL;
              end else if (ins_bad) begin
                status_d = ST_BADPOS;
              end else if (CNT_W'(ins_idx) == cnt_q) begin
                // Append: nothing to move.
                mem_we    = 1'b1;
                mem_waddr = ins_idx;
                mem_wdata = value_i;
                cnt_d     = cnt_q + CNT_W'(1);
              end else begin
                done_d    = 1'b0;
                mem_raddr = last_idx;
                cur_d     = last_idx;
                tgt_d     = ins_idx;
                val_d     = value_i;
                state_d   = S_SHUP;
              end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else if (del_bad) begin
                status_d = ST_BADPOS;
              end else if (del_idx == last_idx) begin
                cnt_d = cnt_q - CNT_W'(1);
              end else begin
                done_d    = 1'b0;
                mem_raddr = del_idx + ADDR_W'(1);
                cur_d     = del_idx + ADDR_W'(1);
                state_d   = S_SHDN;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                done_d    = 1'b0;
                mem_raddr = '0;
                cur_d     = '0;
                state_d   = S_DUMP;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end

      // Move words one slot toward the back, from the last one down to the
      // insertion slot; the read of the next lower slot overlaps the write.
      S_SHUP: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q + ADDR_W'(1);
        if (cur_q == tgt_q) begin
          state_d = S_PUT;
        end else begin
          mem_raddr = cur_q - ADDR_W'(1);
          cur_d     = cur_q - ADDR_W'(1);
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = tgt_q;
        mem_wdata = val_q;
        cnt_d     = cnt_q + CNT_W'(1);
        done_d    = 1'b1;
        status_d  = ST_OK;
        vout_d    = '0;
        last_d    = 1'b1;
        state_d   = S_WAIT;
      end

      // Move words one slot toward the front, closing the gap.
      S_SHDN: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q - ADDR_W'(1);
        if (cur_q == last_idx) begin
          cnt_d    = cnt_q - CNT_W'(1);
          done_d   = 1'b1;
          status_d = ST_OK;
          vout_d   = '0;
          last_d   = 1'b1;
          state_d  = S_WAIT;
        end else begin
          mem_raddr = cur_q + ADDR_W'(1);
          cur_d     = cur_q + ADDR_W'(1);
        end
      end

      S_DUMP: begin
        done_d   = 1'b1;
        status_d = ST_OK;
        vout_d   = mem_rdata;
        last_d   = (cur_q == last_idx);
        if (cur_q == last_idx) begin
          state_d = S_WAIT;
        end else begin
          mem_raddr = cur_q + ADDR_W'(1);
          cur_d     = cur_q + ADDR_W'(1);
        end
      end

      default: begin
        state_d = S_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_WAIT;
      cnt_q    <= '0;
      cur_q    <= '0;
      tgt_q    <= '0;
      val_q    <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      vout_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      cur_q    <= cur_d;
      tgt_q    <= tgt_d;
      val_q    <= val_d;
      done_q   <= done_d;
      status_q <= status_d;
      vout_q   <= vout_d;
      last_q   <= last_d;
    end
  end

  ple_ram #(
    .Width(VAL_W),
    .Depth(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign busy_o      = (state_q != S_WAIT);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign count_o     = COUNT_W'(cnt_q);
  assign value_out_o = vout_q;
  assign last_o      = last_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds the store depth");

  a_dump_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |=> done_o)
    else $error("dump stream broke before its last word");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_FULL) |-> cnt_q == CNT_W'(DEPTH))
    else $error("full status reported on a list that is not full");

  a_shift_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHUP) || (state_q == S_PUT) |-> cnt_q < CNT_W'(DEPTH))
    else $error("insert in progress on a full list");

  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> last_o && (value_out_o == '0))
    else $error("error result not a single zero word");
`endif

endmodule

`default_nettype wire
